>>> src/pdamd_pkg.sv
// ---------------------------------------------------------------------------
// PD angle motor drive package
// Field widths, register indexes and fixed constants shared by the channel
// interfaces and the controller.
// ---------------------------------------------------------------------------
package pdamd_pkg;

  localparam int ANGLE_W   = 13;
  localparam int TIME_W    = 32;
  localparam int GAIN_W    = 16;
  localparam int ERR_W     = 14;
  localparam int DRIVE_W   = 9;
  localparam int DUTY_W    = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_ANGLE = 2'd0,
    REG_PROP_GAIN    = 2'd1,
    REG_DERIV_GAIN   = 2'd2
  } cfg_reg_t;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST = 16'd256;

  // Internal arithmetic widths.
  localparam int DIFF_W    = ERR_W + 1;      // error minus previous error
  localparam int QUO_W     = 24;             // |diff| * 1000 fits here
  localparam int DERIV_W   = QUO_W + 1;      // signed derivative
  localparam int ED_W      = DERIV_W + 1;    // error + derivative
  localparam int ACC_W     = 42;             // kp*err + kd*deriv
  localparam int FRAC_W    = 12;             // Q8.8 gain times 1/16 units
  localparam logic [DUTY_W-1:0] DRIVE_MAX = 8'd255;

endpackage

>>> src/pdamd_in_if.sv
// ---------------------------------------------------------------------------
// PD angle motor drive input channel
// Valid/ready channel carrying one angle sample and its timestamp.
// ---------------------------------------------------------------------------
interface pdamd_in_if;
  logic                               valid;
  logic                               ready;
  logic [pdamd_pkg::ANGLE_W-1:0]      measured_angle;
  logic [pdamd_pkg::TIME_W-1:0]       now_ms;

  modport source (output valid, output measured_angle, output now_ms, input ready);
  modport sink   (input valid, input measured_angle, input now_ms, output ready);
endinterface

>>> src/pdamd_out_if.sv
// ---------------------------------------------------------------------------
// PD angle motor drive result channel
// Valid/ready channel carrying the duties, the drive and the angle error.
// ---------------------------------------------------------------------------
interface pdamd_out_if;
  logic                               valid;
  logic                               ready;
  logic [pdamd_pkg::DUTY_W-1:0]       fwd_duty;
  logic [pdamd_pkg::DUTY_W-1:0]       back_duty;
  logic signed [pdamd_pkg::DRIVE_W-1:0] drive;
  logic signed [pdamd_pkg::ERR_W-1:0] angle_error;

  modport source (output valid, output fwd_duty, output back_duty, output drive,
                  output angle_error, input ready);
  modport sink   (input valid, input fwd_duty, input back_duty, input drive,
                  input angle_error, output ready);
endinterface

>>> src/pd_angle_motor_drive.sv
// ---------------------------------------------------------------------------
// PD angle motor drive
// Proportional-derivative angle controller with forward/backward PWM duties.
// ---------------------------------------------------------------------------
// A new request is accepted only in the idle state, so one request is
// processed at a time through the bit-serial divider
// (24 steps, one quotient bit a cycle) and the bit-serial multiplier
// (16 steps, one gain bit a cycle) sharing one sequencer.
// The output register lets the next request start while a result waits.
// Reset (synchronous, rst_n low): target 0, prop gain 256, deriv gain 0,
// previous error and timestamp 0, no result pending.
module pd_angle_motor_drive (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pdamd_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [pdamd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  pdamd_in_if.sink                            in_ch,
  pdamd_out_if.source                         out_ch
);

  localparam int ANGLE_W = pdamd_pkg::ANGLE_W;
  localparam int TIME_W  = pdamd_pkg::TIME_W;
  localparam int GAIN_W  = pdamd_pkg::GAIN_W;
  localparam int ERR_W   = pdamd_pkg::ERR_W;
  localparam int DIFF_W  = pdamd_pkg::DIFF_W;
  localparam int QUO_W   = pdamd_pkg::QUO_W;
  localparam int DERIV_W = pdamd_pkg::DERIV_W;
  localparam int ED_W    = pdamd_pkg::ED_W;
  localparam int ACC_W   = pdamd_pkg::ACC_W;
  localparam int FRAC_W  = pdamd_pkg::FRAC_W;
  localparam int DUTY_W  = pdamd_pkg::DUTY_W;
  localparam int DRIVE_W = pdamd_pkg::DRIVE_W;
  localparam int CNT_W   = 5;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(GAIN_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_SUM,
    ST_MUL,
    ST_FIN
  } state_t;

  // Control state.
  state_t                     state_r, state_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [ANGLE_W-1:0]         target_r, target_nxt;
  logic [GAIN_W-1:0]          kp_r, kp_nxt;
  logic [GAIN_W-1:0]          kd_r, kd_nxt;
  logic signed [ERR_W-1:0]    last_err_r, last_err_nxt;
  logic [TIME_W-1:0]          last_time_r, last_time_nxt;
  logic                       out_valid_r, out_valid_nxt;

  // Datapath.
  logic signed [ERR_W-1:0]    err_r, err_nxt;
  logic signed [DIFF_W-1:0]   diff_r, diff_nxt;
  logic [TIME_W-1:0]          elapsed_r, elapsed_nxt;
  logic                       dneg_r, dneg_nxt;
  logic [QUO_W-1:0]           num_r, num_nxt;
  logic [TIME_W-1:0]          rem_r, rem_nxt;
  logic [GAIN_W-1:0]          kp_sh_r, kp_sh_nxt;
  logic [GAIN_W-1:0]          kd_sh_r, kd_sh_nxt;
  logic signed [DERIV_W-1:0]  deriv_r, deriv_nxt;
  logic signed [ED_W-1:0]     ed_r, ed_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic [DUTY_W-1:0]          fwd_r, fwd_nxt;
  logic [DUTY_W-1:0]          back_r, back_nxt;
  logic signed [DRIVE_W-1:0]  drive_r, drive_nxt;
  logic signed [ERR_W-1:0]    aerr_r, aerr_nxt;

  // Combinational helpers.
  logic                       in_acc;
  logic signed [ERR_W-1:0]    new_err;
  logic [DIFF_W-2:0]          diff_abs;
  logic [TIME_W:0]            rem_sh;
  logic [TIME_W+1:0]          rem_sub;
  logic                       rem_ge;
  logic [QUO_W-1:0]           quo;
  logic signed [ACC_W-1:0]    term;
  logic [ACC_W-1:0]           acc_abs;
  logic                       sat;
  logic [DUTY_W-1:0]          dmag;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.fwd_duty    = fwd_r;
  assign out_ch.back_duty   = back_r;
  assign out_ch.drive       = drive_r;
  assign out_ch.angle_error = aerr_r;

  assign new_err = $signed({1'b0, target_r}) - $signed({1'b0, in_ch.measured_angle});

  // 1000 * |diff| = 1024*|diff| - 16*|diff| - 8*|diff|.
  assign diff_abs = diff_r[DIFF_W-1] ? (DIFF_W-1)'(-diff_r) : diff_r[DIFF_W-2:0];

  // One restoring division step: bring down the next dividend bit.
  assign rem_sh  = {rem_r, num_r[QUO_W-1]};
  assign rem_sub = {1'b0, rem_sh} - {2'b00, elapsed_r};
  assign rem_ge  = !rem_sub[TIME_W+1];

  // A zero elapsed time gives a zero derivative.
  assign quo = (elapsed_r == '0) ? '0 : num_r;

  always_comb begin
    unique case ({kp_sh_r[GAIN_W-1], kd_sh_r[GAIN_W-1]})
      2'b10:   term = ACC_W'(err_r);
      2'b01:   term = ACC_W'(deriv_r);
      2'b11:   term = ACC_W'(ed_r);
      default: term = '0;
    endcase
  end

  assign acc_abs = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : acc_r;
  assign sat     = |acc_abs[ACC_W-1:FRAC_W+DUTY_W];
  assign dmag    = sat ? pdamd_pkg::DRIVE_MAX : acc_abs[FRAC_W+DUTY_W-1:FRAC_W];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    target_nxt    = target_r;
    kp_nxt        = kp_r;
    kd_nxt        = kd_r;
    last_err_nxt  = last_err_r;
    last_time_nxt = last_time_r;
    out_valid_nxt = out_valid_r;
    err_nxt       = err_r;
    diff_nxt      = diff_r;
    elapsed_nxt   = elapsed_r;
    dneg_nxt      = dneg_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    kp_sh_nxt     = kp_sh_r;
    kd_sh_nxt     = kd_sh_r;
    deriv_nxt     = deriv_r;
    ed_nxt        = ed_r;
    acc_nxt       = acc_r;
    fwd_nxt       = fwd_r;
    back_nxt      = back_r;
    drive_nxt     = drive_r;
    aerr_nxt      = aerr_r;

    if (cfg_we) begin
      unique case (cfg_idx)
        pdamd_pkg::REG_TARGET_ANGLE: target_nxt = cfg_wdata[ANGLE_W-1:0];
        pdamd_pkg::REG_PROP_GAIN:    kp_nxt     = cfg_wdata[GAIN_W-1:0];
        pdamd_pkg::REG_DERIV_GAIN:   kd_nxt     = cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end

    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          err_nxt       = new_err;
          diff_nxt      = DIFF_W'(new_err) - DIFF_W'(last_err_r);
          elapsed_nxt   = in_ch.now_ms - last_time_r;
          last_err_nxt  = new_err;
          last_time_nxt = in_ch.now_ms;
          kp_sh_nxt     = kp_r;
          kd_sh_nxt     = kd_r;
          state_nxt     = ST_PREP;
        end
      end
      ST_PREP: begin
        dneg_nxt  = diff_r[DIFF_W-1];
        num_nxt   = ({diff_abs, 10'b0}) - QUO_W'({diff_abs, 4'b0})
                    - QUO_W'({diff_abs, 3'b0});
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = rem_ge ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
        num_nxt = {num_r[QUO_W-2:0], rem_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        deriv_nxt = dneg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        ed_nxt    = ED_W'(err_r)
                    + ED_W'(dneg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo}));
        acc_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        // Both products together, most significant gain bit first.
        acc_nxt   = (acc_r <<< 1) + term;
        kp_sh_nxt = {kp_sh_r[GAIN_W-2:0], 1'b0};
        kd_sh_nxt = {kd_sh_r[GAIN_W-2:0], 1'b0};
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == MUL_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          fwd_nxt       = acc_r[ACC_W-1] ? '0 : dmag;
          back_nxt      = acc_r[ACC_W-1] ? dmag : '0;
          drive_nxt     = acc_r[ACC_W-1] ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
          aerr_nxt      = err_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      target_r    <= '0;
      kp_r        <= pdamd_pkg::PROP_GAIN_RST;
      kd_r        <= '0;
      last_err_r  <= '0;
      last_time_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      target_r    <= target_nxt;
      kp_r        <= kp_nxt;
      kd_r        <= kd_nxt;
      last_err_r  <= last_err_nxt;
      last_time_r <= last_time_nxt;
      out_valid_r <= out_valid_nxt;
    end
    err_r     <= err_nxt;
    diff_r    <= diff_nxt;
    elapsed_r <= elapsed_nxt;
    dneg_r    <= dneg_nxt;
    num_r     <= num_nxt;
    rem_r     <= rem_nxt;
    kp_sh_r   <= kp_sh_nxt;
    kd_sh_r   <= kd_sh_nxt;
    deriv_r   <= deriv_nxt;
    ed_r      <= ed_nxt;
    acc_r     <= acc_nxt;
    fwd_r     <= fwd_nxt;
    back_r    <= back_nxt;
    drive_r   <= drive_nxt;
    aerr_r    <= aerr_nxt;
  end

endmodule
